[hw/rtl/dfr_pkg.sv]
package dfr_pkg;

    localparam int MAX_PAYLOAD_BYTES = 64;
    localparam int STORE_DEPTH       = 64;
    localparam int ADDR_W            = $clog2(STORE_DEPTH);
    localparam int LEN_W             = 7;

    localparam logic [7:0] CRC_POLY         = 8'h07;
    localparam logic [7:0] CRC_INIT         = 8'h00;
    localparam logic [7:0] SYNC_FIRST_RST   = 8'hA5;
    localparam logic [7:0] SYNC_SECOND_RST  = 8'h5A;
    localparam logic [7:0] MAX_LEN_BYTE     = 8'(MAX_PAYLOAD_BYTES);

    // APB register map, word index taken from paddr[2]
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CRC_FAIL = 2'd1,
        ST_BAD_LEN  = 2'd2
    } frame_status_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_BAD_LEN,
        EMIT_CRC_FAIL,
        EMIT_EMPTY,
        EMIT_PAYLOAD
    } emit_kind_t;

    typedef struct packed {
        logic       take_type;
        logic       take_len;
        logic       take_pay;
        logic       drain_clr;
        logic       drain_step;
        emit_kind_t emit;
    } dfr_cmd_t;

    typedef struct packed {
        logic hit_first;
        logic hit_second;
        logic len_over;
        logic len_zero;
        logic pay_last;
        logic crc_ok;
        logic held_zero;
        logic drain_last;
        logic out_busy;
        logic out_free;
    } dfr_stat_t;

    // CRC-8, MSB first, one byte per call
    function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/dfr_rx_if.sv]
interface dfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/dfr_res_if.sv]
interface dfr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_len;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic [15:0] crc_fail_total;
    logic [15:0] bad_len_total;

    modport source (
        output valid, output status, output frame_type, output frame_len,
        output payload_byte, output byte_index, output last,
        output crc_fail_total, output bad_len_total,
        input  ready
    );
    modport sink (
        input  valid, input status, input frame_type, input frame_len,
        input  payload_byte, input byte_index, input last,
        input  crc_fail_total, input bad_len_total,
        output ready
    );
endinterface

[hw/rtl/dfr_ctrl.sv]
module dfr_ctrl
    import dfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dfr_stat_t stat,
    output dfr_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_HUNT_A,
        S_HUNT_B,
        S_TYPE,
        S_LEN,
        S_PAY,
        S_CHECK,
        S_DRAIN_RD,
        S_DRAIN_WR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   parsing;
    logic   fire;

    assign parsing  = (state_reg != S_DRAIN_RD) && (state_reg != S_DRAIN_WR);
    // every request, not only one that may produce a result, needs the output register empty
    assign in_ready = parsing && !stat.out_busy;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.emit   = EMIT_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_HUNT_A:
            begin
                if (fire && stat.hit_first)
                begin
                    state_next = S_HUNT_B;
                end
            end
            S_HUNT_B:
            begin
                if (fire)
                begin
                    if (stat.hit_second)
                    begin
                        state_next = S_TYPE;
                    end
                    else if (!stat.hit_first)
                    begin
                        state_next = S_HUNT_A;
                    end
                end
            end
            S_TYPE:
            begin
                if (fire)
                begin
                    cmd.take_type = 1'b1;
                    state_next    = S_LEN;
                end
            end
            S_LEN:
            begin
                if (fire)
                begin
                    if (stat.len_over)
                    begin
                        cmd.emit   = EMIT_BAD_LEN;
                        state_next = S_HUNT_A;
                    end
                    else
                    begin
                        cmd.take_len = 1'b1;
                        state_next   = stat.len_zero ? S_CHECK : S_PAY;
                    end
                end
            end
            S_PAY:
            begin
                if (fire)
                begin
                    cmd.take_pay = 1'b1;
                    if (stat.pay_last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (fire)
                begin
                    if (!stat.crc_ok)
                    begin
                        cmd.emit   = EMIT_CRC_FAIL;
                        state_next = S_HUNT_A;
                    end
                    else if (stat.held_zero)
                    begin
                        cmd.emit   = EMIT_EMPTY;
                        state_next = S_HUNT_A;
                    end
                    else
                    begin
                        cmd.drain_clr = 1'b1;
                        state_next    = S_DRAIN_RD;
                    end
                end
            end
            S_DRAIN_RD:
            begin
                // memory read of the current index lands next cycle
                state_next = S_DRAIN_WR;
            end
            S_DRAIN_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = EMIT_PAYLOAD;
                    cmd.drain_step = 1'b1;
                    state_next     = stat.drain_last ? S_HUNT_A : S_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = S_HUNT_A;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT_A;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != EMIT_NONE) |-> stat.out_free)
        else $error("result loaded while output register still held");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN_RD || state_reg == S_DRAIN_WR) |-> !stat.held_zero)
        else $error("drain entered for an empty frame");

    a_check_after_pay: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_pay && stat.pay_last) |=> (state_reg == S_CHECK))
        else $error("last payload byte did not lead to CRC check");

endmodule

[hw/rtl/dfr_datapath.sv]
module dfr_datapath
    import dfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  dfr_cmd_t     cmd,
    output dfr_stat_t    stat,
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   sync_first,
    input  logic [7:0]   sync_second,
    dfr_res_if.source    res
);

    logic [7:0]        held_type_reg;
    logic [LEN_W-1:0]  held_length_reg;
    logic [LEN_W-1:0]  payload_count_reg;
    logic [7:0]        crc_reg;
    logic [7:0]        crc_next;
    logic [15:0]       crc_fail_reg;
    logic [15:0]       crc_fail_next;
    logic [15:0]       bad_len_reg;
    logic [15:0]       bad_len_next;
    logic [ADDR_W-1:0] drain_idx_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        pay_mem [STORE_DEPTH];

    logic              out_valid_reg;
    frame_status_t     out_status_reg;
    logic [7:0]        out_type_reg;
    logic [7:0]        out_len_reg;
    logic [7:0]        out_byte_reg;
    logic [ADDR_W-1:0] out_idx_reg;
    logic              out_last_reg;
    logic [15:0]       out_crc_fail_reg;
    logic [15:0]       out_bad_len_reg;

    frame_status_t     out_status_next;
    logic [7:0]        out_len_next;
    logic [7:0]        out_byte_next;
    logic [ADDR_W-1:0] out_idx_next;
    logic              out_last_next;
    logic              load;

    assign load = (cmd.emit != EMIT_NONE);

    always_comb
    begin
        stat.hit_first  = (rx_byte == sync_first);
        stat.hit_second = (rx_byte == sync_second);
        stat.len_over   = (rx_byte > MAX_LEN_BYTE);
        stat.len_zero   = (rx_byte == 8'd0);
        stat.pay_last   = ((payload_count_reg + LEN_W'(1)) >= held_length_reg);
        stat.crc_ok     = (rx_byte == crc_reg);
        stat.held_zero  = (held_length_reg == '0);
        stat.drain_last = ((LEN_W'(drain_idx_reg) + LEN_W'(1)) == held_length_reg);
        stat.out_busy   = out_valid_reg;
        stat.out_free   = !out_valid_reg || res.ready;
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (cmd.take_type)
        begin
            crc_next = crc8_update(CRC_INIT, rx_byte);
        end
        else if (cmd.take_len || cmd.take_pay)
        begin
            crc_next = crc8_update(crc_reg, rx_byte);
        end
    end

    // saturating error counters; result items carry the updated totals
    assign crc_fail_next = (cmd.emit == EMIT_CRC_FAIL && crc_fail_reg != 16'hFFFF)
                           ? crc_fail_reg + 16'd1 : crc_fail_reg;
    assign bad_len_next  = (cmd.emit == EMIT_BAD_LEN && bad_len_reg != 16'hFFFF)
                           ? bad_len_reg + 16'd1 : bad_len_reg;

    always_comb
    begin
        out_status_next = ST_GOOD;
        out_len_next    = 8'd0;
        out_byte_next   = 8'd0;
        out_idx_next    = '0;
        out_last_next   = 1'b1;
        case (cmd.emit)
            EMIT_BAD_LEN:
            begin
                out_status_next = ST_BAD_LEN;
                out_len_next    = rx_byte;
            end
            EMIT_CRC_FAIL:
            begin
                out_status_next = ST_CRC_FAIL;
                out_len_next    = 8'(held_length_reg);
            end
            EMIT_PAYLOAD:
            begin
                out_len_next  = 8'(held_length_reg);
                out_byte_next = rd_data_reg;
                out_idx_next  = drain_idx_reg;
                out_last_next = stat.drain_last;
            end
            default:
            begin
                out_status_next = ST_GOOD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_type_reg     <= '0;
            held_length_reg   <= '0;
            payload_count_reg <= '0;
            crc_reg           <= CRC_INIT;
            crc_fail_reg      <= '0;
            bad_len_reg       <= '0;
            drain_idx_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            crc_reg      <= crc_next;
            crc_fail_reg <= crc_fail_next;
            bad_len_reg  <= bad_len_next;
            if (cmd.take_type)
            begin
                held_type_reg <= rx_byte;
            end
            if (cmd.take_len)
            begin
                held_length_reg   <= rx_byte[LEN_W-1:0];
                payload_count_reg <= '0;
            end
            else if (cmd.take_pay)
            begin
                payload_count_reg <= payload_count_reg + LEN_W'(1);
            end
            if (cmd.drain_clr)
            begin
                drain_idx_reg <= '0;
            end
            else if (cmd.drain_step)
            begin
                drain_idx_reg <= drain_idx_reg + ADDR_W'(1);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_pay)
        begin
            pay_mem[payload_count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        rd_data_reg <= pay_mem[drain_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg   <= out_status_next;
            out_type_reg     <= held_type_reg;
            out_len_reg      <= out_len_next;
            out_byte_reg     <= out_byte_next;
            out_idx_reg      <= out_idx_next;
            out_last_reg     <= out_last_next;
            out_crc_fail_reg <= crc_fail_next;
            out_bad_len_reg  <= bad_len_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.status         = out_status_reg;
    assign res.frame_type     = out_type_reg;
    assign res.frame_len      = out_len_reg;
    assign res.payload_byte   = out_byte_reg;
    assign res.byte_index     = out_idx_reg;
    assign res.last           = out_last_reg;
    assign res.crc_fail_total = out_crc_fail_reg;
    assign res.bad_len_total  = out_bad_len_reg;

    a_crc_fail_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        crc_fail_reg >= $past(crc_fail_reg))
        else $error("CRC failure counter went backward");

    a_bad_len_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        bad_len_reg >= $past(bad_len_reg))
        else $error("bad length counter went backward");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        payload_count_reg <= held_length_reg)
        else $error("payload count ran past frame length");

endmodule

[hw/rtl/sync_length_crc8_deframer_unit.sv]
// Receive-side frame parser: takes one byte per request on rx and hunts for
// sync_first then sync_second, reads type and length, stores up to 64 payload
// bytes in an internal 64x8 RAM and checks a CRC-8 (poly 0x07, init 0) over
// type, length and payload against the closing byte. Bytes are taken at one
// per cycle while the output register is empty; a byte that produces a
// result holds rx off until the output register has been taken. A good
// frame of N payload bytes then drains from the RAM, each result by a
// registered RAM read and then a load of the output register, so rx stays
// stalled for the drain after the CRC byte, longer if res is back-pressured.
// The RAM needs no clearing after reset. sync_first sits at byte address 0
// and sync_second at 4; write them only while the parser is idle.
module sync_length_crc8_deframer_unit
    import dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dfr_rx_if.sink      rx,
    dfr_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic       cfg_wr;
    dfr_cmd_t   cmd;
    dfr_stat_t  stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SYNC_FIRST:  sync_first_reg  <= pwdata[7:0];
                REG_SYNC_SECOND: sync_second_reg <= pwdata[7:0];
                default:         sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SYNC_FIRST:  prdata = {24'd0, sync_first_reg};
            REG_SYNC_SECOND: prdata = {24'd0, sync_second_reg};
            default:         prdata = 32'd0;
        endcase
    end

    dfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dfr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .rx_byte     (rx.rx_byte),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .res         (res)
    );

endmodule
